[hw/rtl/cwst_pkg.sv]
// ----------------------------------------------------------------------------
// Circle window span table package
// Shared constants, command codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwst_pkg;

   // Default screen size.
   localparam int SCREEN_W_DEF = 240;
   localparam int SCREEN_H_DEF = 160;

   // Channel widths.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;
   localparam int EDGE_W      = 8;
   localparam int SPAN_W      = 2 * EDGE_W;

   // Request kinds carried on tuser.
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Span write selectors: which of the four octant rows is written.
   localparam logic [1:0] SEL_UP_A   = 2'd0;
   localparam logic [1:0] SEL_DOWN_A = 2'd1;
   localparam logic [1:0] SEL_UP_B   = 2'd2;
   localparam logic [1:0] SEL_DOWN_B = 2'd3;

   typedef enum logic [3:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DRAW_CLEAR,
      ST_SPAN_0,
      ST_SPAN_1,
      ST_SPAN_2,
      ST_SPAN_3,
      ST_COPY_RD,
      ST_COPY_WR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       draw_start;
      logic       read_start;
      logic       clr_wr;
      logic       span_wr;
      logic [1:0] span_sel;
      logic       advance;
      logic       copy_rd;
      logic       copy_wr;
      logic       rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic loop_done;
      logic d_nonneg;
      logic out_blocked;
   } status_type;

   // Clamp an edge to 0..lim-1.
   function automatic logic [EDGE_W-1:0] edge_clamp(input logic signed [11:0] v,
                                                    input logic signed [11:0] lim);
      logic signed [11:0] top;
      top = lim - 12'sd1;
      if (v < 12'sd0) begin
         return '0;
      end else if (v >= lim) begin
         return top[EDGE_W-1:0];
      end else begin
         return v[EDGE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[hw/rtl/circle_window_span_table.sv]
// ----------------------------------------------------------------------------
// Circle window span table
// Per-scanline window spans of a filled circle drawn by the midpoint method,
// stored in a table of SCREEN_H+1 entries and read back one line at a time.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   req_*     in         tuser: command; tdata: center_x, center_y, radius, line
//   rsp_*     out        tdata: right_edge, left_edge (one per read)
//
// A read issues the memory read, then loads the result register from the
// read data. A draw clears every entry, then walks the octant steps,
// writing the two near rows on each step and the two far rows on steps
// that move them, ends on one closing check, then copies entry zero into
// the wrap entry; the single write port sets the pace.
// After reset a clearing pass over all SCREEN_H+1 entries runs before the first
// transaction is taken. A stalled result holds every transaction at the
// input until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module circle_window_span_table #(
   parameter int SCREEN_W = cwst_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = cwst_pkg::SCREEN_H_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [9:0] center_x, [19:10] center_y, [27:20] radius, [35:28] line, [39:36] zero
   input  wire logic [cwst_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] command
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] right_edge, [15:8] left_edge
   output logic      [cwst_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   cwst_pkg::cmd_type    cmd;
   cwst_pkg::status_type status;

   cwst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   cwst_dp #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[hw/rtl/cwst_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwst_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 161,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/cwst_ctrl.sv]
// ----------------------------------------------------------------------------
// Circle window span table controller
// Sequences the table clear, the octant walk, the wrap copy and reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwst_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_command,
   output logic                        req_tready,
   input  wire cwst_pkg::status_type   status,
   output cwst_pkg::cmd_type           cmd
);

   cwst_pkg::state_type state_ff;
   cwst_pkg::state_type state_in;

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwst_pkg::ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         cwst_pkg::ST_INIT_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = cwst_pkg::ST_IDLE;
            end
         end
         cwst_pkg::ST_IDLE: begin
            req_tready = !status.out_blocked;
            if (req_tvalid && !status.out_blocked) begin
               if (req_command == cwst_pkg::CMD_DRAW) begin
                  cmd.draw_start = 1'b1;
                  state_in       = cwst_pkg::ST_DRAW_CLEAR;
               end else begin
                  cmd.read_start = 1'b1;
                  state_in       = cwst_pkg::ST_READ;
               end
            end
         end
         cwst_pkg::ST_READ: begin
            cmd.rsp_load = 1'b1;
            state_in     = cwst_pkg::ST_IDLE;
         end
         cwst_pkg::ST_DRAW_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = cwst_pkg::ST_SPAN_0;
            end
         end
         cwst_pkg::ST_SPAN_0: begin
            if (status.loop_done) begin
               state_in = cwst_pkg::ST_COPY_RD;
            end else begin
               cmd.span_wr  = 1'b1;
               cmd.span_sel = cwst_pkg::SEL_UP_A;
               state_in     = cwst_pkg::ST_SPAN_1;
            end
         end
         cwst_pkg::ST_SPAN_1: begin
            cmd.span_wr  = 1'b1;
            cmd.span_sel = cwst_pkg::SEL_DOWN_A;
            if (status.d_nonneg) begin
               state_in = cwst_pkg::ST_SPAN_2;
            end else begin
               cmd.advance = 1'b1;
               state_in    = cwst_pkg::ST_SPAN_0;
            end
         end
         cwst_pkg::ST_SPAN_2: begin
            cmd.span_wr  = 1'b1;
            cmd.span_sel = cwst_pkg::SEL_UP_B;
            state_in     = cwst_pkg::ST_SPAN_3;
         end
         cwst_pkg::ST_SPAN_3: begin
            cmd.span_wr  = 1'b1;
            cmd.span_sel = cwst_pkg::SEL_DOWN_B;
            cmd.advance  = 1'b1;
            state_in     = cwst_pkg::ST_SPAN_0;
         end
         cwst_pkg::ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = cwst_pkg::ST_COPY_WR;
         end
         cwst_pkg::ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            state_in    = cwst_pkg::ST_IDLE;
         end
         default: begin
            state_in = cwst_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/cwst_dp.sv]
// ----------------------------------------------------------------------------
// Circle window span table datapath
// Midpoint circle registers, span arithmetic, the span memory and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwst_dp #(
   parameter int SCREEN_W = cwst_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = cwst_pkg::SCREEN_H_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire cwst_pkg::cmd_type                  cmd,
   output cwst_pkg::status_type                    status,
   input  wire logic [cwst_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic      [cwst_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int DEPTH = SCREEN_H + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(SCREEN_H);
   localparam logic signed [11:0] ROW_LIMIT  = 12'(SCREEN_H);
   localparam logic signed [11:0] EDGE_LIMIT = 12'(SCREEN_W);
   localparam logic [8:0]         LINE_LIMIT = 9'(SCREEN_H);

   // Request fields.
   logic signed [9:0] req_cx;
   logic signed [9:0] req_cy;
   logic [7:0]        req_radius;
   logic [7:0]        req_line;

   assign req_cx     = req_tdata[9:0];
   assign req_cy     = req_tdata[19:10];
   assign req_radius = req_tdata[27:20];
   assign req_line   = req_tdata[35:28];

   // Walk registers.
   logic signed [9:0]  cx_ff;
   logic signed [9:0]  cy_ff;
   logic signed [9:0]  a_ff;
   logic signed [9:0]  b_ff;
   logic signed [11:0] d_ff;
   logic [IDX_W-1:0]   clr_cnt_ff;
   logic               rd_zero_ff;
   logic               rsp_valid_ff;
   logic [cwst_pkg::SPAN_W-1:0] rsp_data_ff;

   logic signed [9:0]  a_in;
   logic signed [9:0]  b_in;
   logic signed [11:0] d_in;
   logic signed [11:0] b_twice;
   logic signed [11:0] a_twice;
   logic               d_nonneg;

   // Span arithmetic.
   logic signed [11:0] row;
   logic signed [11:0] offset;
   logic signed [11:0] half;
   logic signed [11:0] cx_ext;
   logic               row_ok;
   logic [cwst_pkg::EDGE_W-1:0] right_edge;
   logic [cwst_pkg::EDGE_W-1:0] left_edge;

   // Memory ports.
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [cwst_pkg::SPAN_W-1:0]  wr_data;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic [cwst_pkg::SPAN_W-1:0]  rd_data;
   logic [8:0]                   line_ext;
   logic                         line_ok;

   assign d_nonneg = (d_ff >= 12'sd0);

   // Midpoint step: b drops when d is not negative, then d moves on.
   always_comb begin
      a_in    = a_ff + 10'sd1;
      b_in    = d_nonneg ? (b_ff - 10'sd1) : b_ff;
      b_twice = d_nonneg ? {b_in[9], b_in, 1'b0} : 12'sd0;
      a_twice = {a_ff[9], a_ff, 1'b0};
      d_in    = d_ff - b_twice + a_twice + 12'sd3;
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_start) begin
         cx_ff <= req_cx;
         cy_ff <= req_cy;
         a_ff  <= '0;
         b_ff  <= $signed({2'b00, req_radius});
         d_ff  <= 12'sd1 - $signed({4'b0000, req_radius});
      end else if (cmd.advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         d_ff <= d_in;
      end
   end

   // Row and half width of the current octant write.
   always_comb begin
      cx_ext = {{2{cx_ff[9]}}, cx_ff};
      offset = cmd.span_sel[1] ? {{2{b_ff[9]}}, b_ff} : {{2{a_ff[9]}}, a_ff};
      half   = cmd.span_sel[1] ? {{2{a_ff[9]}}, a_ff} : {{2{b_ff[9]}}, b_ff};
      row    = cmd.span_sel[0] ? ({{2{cy_ff[9]}}, cy_ff} + offset)
                               : ({{2{cy_ff[9]}}, cy_ff} - offset);
      row_ok     = (row >= 12'sd0) && (row < ROW_LIMIT);
      right_edge = cwst_pkg::edge_clamp(cx_ext + half, EDGE_LIMIT);
      left_edge  = cwst_pkg::edge_clamp(cx_ext - half, EDGE_LIMIT);
   end

   // Clear counter sweeps every entry; reset starts it at zero.
   always_ff @(posedge clock) begin
      if (reset || cmd.draw_start) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= (clr_cnt_ff == LAST_IDX) ? '0 : clr_cnt_ff + 1'b1;
      end
   end

   // Write port: clear, span or wrap copy.
   always_comb begin
      wr_en   = cmd.clr_wr || (cmd.span_wr && row_ok) || cmd.copy_wr;
      wr_addr = LAST_IDX;
      wr_data = rd_data;
      if (cmd.clr_wr) begin
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.span_wr) begin
         wr_addr = row[IDX_W-1:0];
         wr_data = {left_edge, right_edge};
      end
   end

   // Read port: entry zero for the copy or an out-of-range line, else the requested line.
   always_comb begin
      line_ext = {1'b0, req_line};
      line_ok  = (line_ext <= LINE_LIMIT);
      rd_en    = cmd.read_start || cmd.copy_rd;
      if (cmd.copy_rd || !line_ok) begin
         rd_addr = '0;
      end else begin
         rd_addr = line_ext[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         rd_zero_ff <= !line_ok;
      end
   end

   cwst_ram #(
      .DATA_W (cwst_pkg::SPAN_W),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rd_zero_ff ? '0 : rd_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status back to the controller.
   always_comb begin
      status.clr_last    = (clr_cnt_ff == LAST_IDX);
      status.loop_done   = (b_ff < a_ff);
      status.d_nonneg    = d_nonneg;
      status.out_blocked = rsp_valid_ff && !rsp_tready;
   end

`ifndef SYNTHESIS
   // A result is never loaded over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // Only one write source is active at a time.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_wr, cmd.span_wr, cmd.copy_wr}))
      else $error("conflicting memory writes");

   // Span writes happen only inside the walk.
   assert property (@(posedge clock) disable iff (reset)
      cmd.span_wr |-> (b_ff >= a_ff))
      else $error("span write after walk end");

   // Stored spans are ordered and on screen.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.span_wr && row_ok) |->
         (left_edge <= right_edge) && ({1'b0, right_edge} < 9'(SCREEN_W)))
      else $error("span edges out of order or off screen");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Circle window span table testbench
// Drives draw and read transactions into the span table. Each read is checked
// against a fixed span or an in-bench midpoint circle tracer. The stimulus is a
// directed table followed by random draw-then-read sequences. Both stream sides
// idle at random, in several phases, with one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_PERIOD     = 10;
   localparam int SCREEN_W       = cwst_pkg::SCREEN_W_DEF;
   localparam int SCREEN_H       = cwst_pkg::SCREEN_H_DEF;
   localparam int REQ_TDATA_W    = cwst_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W    = cwst_pkg::RSP_TDATA_W;
   localparam logic CMD_DRAW     = cwst_pkg::CMD_DRAW;
   localparam logic CMD_READ     = cwst_pkg::CMD_READ;
   localparam int RANDOM_ITEMS   = 825;
   localparam int PHASE_ITEMS    = 80;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 1200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 10;

   // Idle percentages per phase: none, sender, receiver, both.
   localparam int SEND_IDLE_PCT  [4] = '{0, 67, 0, 30};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 67, 30};

   // One table entry, laid out as on rsp_tdata.
   typedef struct packed {
      logic [7:0] left_edge;
      logic [7:0] right_edge;
   } span_type;

   // One row of the directed stimulus; span is used only when fixed is set.
   typedef struct {
      logic     cmd;
      int       cx;
      int       cy;
      int       rad;
      int       ln;
      bit       fixed;
      span_type span;
   } dir_row_type;

   localparam int DIR_N = 25;
   localparam int HOLD_AT = DIR_N + 200;

   dir_row_type directed_rows [DIR_N] = '{
      // Reads after reset, including the wrap entry and beyond the table.
      '{CMD_READ, 0, 0, 0, 0,   1'b1, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 160, 1'b1, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 255, 1'b1, {8'd0, 8'd0}},
      // Radius zero gives a single one-pixel span at the center row.
      '{CMD_DRAW, 100, 50, 0, 0, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 50,  1'b1, {8'd100, 8'd100}},
      '{CMD_READ, 0, 0, 0, 49,  1'b1, {8'd0, 8'd0}},
      // Largest radius: the center row is clamped on both sides.
      '{CMD_DRAW, 120, 80, 255, 0, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 80,  1'b1, {8'd0, 8'd239}},
      '{CMD_READ, 0, 0, 0, 0,   1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 160, 1'b0, {8'd0, 8'd0}},
      // Circles entirely off screen leave the table clear.
      '{CMD_DRAW, -512, -512, 255, 0, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 0,   1'b1, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 160, 1'b1, {8'd0, 8'd0}},
      '{CMD_DRAW, 511, 511, 255, 0, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 159, 1'b1, {8'd0, 8'd0}},
      // Corner circle: the wrap entry copies line zero.
      '{CMD_DRAW, 0, 0, 10, 0, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 0,   1'b1, {8'd0, 8'd10}},
      '{CMD_READ, 0, 0, 0, 160, 1'b1, {8'd0, 8'd10}},
      '{CMD_READ, 0, 0, 0, 5,   1'b0, {8'd0, 8'd0}},
      // Right edge past the screen is clamped to the last column.
      '{CMD_DRAW, 239, 159, 1, 0, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 159, 1'b1, {8'd238, 8'd239}},
      '{CMD_READ, 0, 0, 0, 158, 1'b0, {8'd0, 8'd0}},
      // Negative center column, left edge clamped to zero.
      '{CMD_DRAW, -1, 100, 3, 0, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 100, 1'b0, {8'd0, 8'd0}},
      '{CMD_READ, 0, 0, 0, 161, 1'b1, {8'd0, 8'd0}}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Bench copy of the table and the spans still owed by the block.
   span_type    span_image [SCREEN_H+1];
   span_type    pending_spans [$];
   int          span_errors  = 0;
   int          items_sent   = 0;
   int          req_accepts  = 0;
   int          quiet_cycles = 0;
   int          hold_left    = 0;
   bit          hold_done    = 1'b0;
   int unsigned idle_phase   = 0;
   int          last_cy      = 0;
   int          last_rad     = 0;

   circle_window_span_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Clamp a column to the range 0..SCREEN_W-1.
   function automatic logic [7:0] clamp_col(input int v);
      if (v < 0) begin
         return 8'd0;
      end else if (v >= SCREEN_W) begin
         return 8'(SCREEN_W - 1);
      end
      return 8'(v);
   endfunction

   function automatic span_type chord_span(input int cx, input int half);
      span_type s;
      s.left_edge  = clamp_col(cx - half);
      s.right_edge = clamp_col(cx + half);
      return s;
   endfunction

   // Rows off the screen are dropped.
   function automatic void put_chord(input int row, input span_type s);
      if (row >= 0 && row < SCREEN_H) begin
         span_image[row] = s;
      end
   endfunction

   // Clear the table, trace the circle by octant steps, then fill the wrap entry.
   function automatic void trace_circle(input int cx, input int cy, input int rad);
      int       a;
      int       b;
      int       d;
      span_type s;
      for (int i = 0; i <= SCREEN_H; i++) begin
         span_image[i] = '0;
      end
      a = 0;
      b = rad;
      d = 1 - rad;
      while (b >= a) begin
         s = chord_span(cx, b);
         put_chord(cy - a, s);
         put_chord(cy + a, s);
         if (d >= 0) begin
            s = chord_span(cx, a);
            put_chord(cy - b, s);
            put_chord(cy + b, s);
            b = b - 1;
            d = d - 2 * b;
         end
         d = d + 2 * a + 3;
         a = a + 1;
      end
      span_image[SCREEN_H] = span_image[0];
   endfunction

   // Offer one request transaction and update the bench table once it is taken.
   task automatic send_item(input logic cmd, input logic [9:0] cx, input logic [9:0] cy,
                            input logic [7:0] rad, input logic [7:0] ln,
                            input bit fixed, input span_type fixed_span);
      while ($urandom_range(99) < SEND_IDLE_PCT[idle_phase]) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, ln, rad, cy, cx};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (cmd == CMD_DRAW) begin
         trace_circle($signed(cx), $signed(cy), int'(rad));
      end else if (fixed) begin
         pending_spans.push_back(fixed_span);
      end else if (ln <= SCREEN_H) begin
         pending_spans.push_back(span_image[ln]);
      end else begin
         pending_spans.push_back('0);
      end
      items_sent++;
   endtask

   // Mostly on-screen centers and small radii, with a few large circles.
   task automatic send_random_draw();
      logic [9:0] cx;
      logic [9:0] cy;
      logic [7:0] rad;
      int         roll;
      if ($urandom_range(99) < 70) begin
         cx = 10'($urandom_range(SCREEN_W - 1, 0));
         cy = 10'($urandom_range(SCREEN_H - 1, 0));
      end else begin
         cx = 10'($urandom);
         cy = 10'($urandom);
      end
      roll = $urandom_range(99);
      if (roll < 80) begin
         rad = 8'($urandom_range(40, 0));
      end else if (roll < 95) begin
         rad = 8'($urandom_range(160, 41));
      end else begin
         rad = 8'($urandom_range(255, 161));
      end
      last_cy  = $signed(cy);
      last_rad = rad;
      send_item(CMD_DRAW, cx, cy, rad, 8'($urandom), 1'b0, '0);
   endtask

   // Reads favor the rows the last circle covers; unused fields carry noise.
   task automatic send_random_read();
      logic [7:0] ln;
      int         lo;
      int         hi;
      lo = (last_cy - last_rad < 0) ? 0 : last_cy - last_rad;
      hi = (last_cy + last_rad > SCREEN_H) ? SCREEN_H : last_cy + last_rad;
      if (lo <= hi && $urandom_range(99) < 60) begin
         ln = 8'($urandom_range(hi, lo));
      end else if ($urandom_range(99) < 90) begin
         ln = 8'($urandom_range(SCREEN_H, 0));
      end else begin
         ln = 8'($urandom);
      end
      send_item(CMD_READ, 10'($urandom), 10'($urandom), 8'($urandom), ln, 1'b0, '0);
   endtask

   // Compare one result transaction with the oldest owed span.
   task automatic check_span(input span_type got);
      span_type want;
      if (pending_spans.size() == 0) begin
         span_errors++;
         if (span_errors <= MAX_REPORTS) begin
            $display("unexpected result: left %0d right %0d", got.left_edge, got.right_edge);
         end
      end else begin
         want = pending_spans.pop_front();
         if (got.left_edge !== want.left_edge || got.right_edge !== want.right_edge) begin
            span_errors++;
            if (span_errors <= MAX_REPORTS) begin
               $display("span mismatch: left %0d (want %0d), right %0d (want %0d)",
                        got.left_edge, want.left_edge, got.right_edge, want.right_edge);
            end
         end
      end
   endtask

   // Result side: check accepted spans, then choose the next ready value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_span(span_type'(rsp_tdata));
         end
         if (!hold_done && req_accepts >= HOLD_AT) begin
            // One long hold-off so the block backs up onto its input.
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= RECV_STALL_PCT[idle_phase]);
         end
      end
   end

   // Watchdog on cycles without any transaction; also counts accepted requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_accepts <= req_accepts + 1;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("FAIL circle_window_span_table");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus: directed table, then random draw-then-read sequences and noise.
   initial begin
      int roll;
      int seq_len;
      for (int i = 0; i <= SCREEN_H; i++) begin
         span_image[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].cmd, 10'(directed_rows[i].cx), 10'(directed_rows[i].cy),
                   8'(directed_rows[i].rad), 8'(directed_rows[i].ln),
                   directed_rows[i].fixed, directed_rows[i].span);
      end

      while (items_sent < DIR_N + RANDOM_ITEMS) begin
         idle_phase = ((items_sent - DIR_N) / PHASE_ITEMS) % 4;
         roll = $urandom_range(99);
         if (roll < 80) begin
            send_random_draw();
            seq_len = $urandom_range(12, 3);
            repeat (seq_len) send_random_read();
         end else if (roll < 90) begin
            send_random_read();
         end else begin
            // A draw that nothing reads before the next one.
            send_random_draw();
         end
      end
      req_tvalid <= 1'b0;

      // Wait for every owed span, then give a trailing draw time to finish.
      while (pending_spans.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (span_errors == 0 && pending_spans.size() == 0) begin
         $display("PASS circle_window_span_table");
      end else begin
         $display("FAIL circle_window_span_table");
      end
      $finish;
   end

endmodule
